[hdl/weighted_outer_product_accumulator_defines.svh]
// assertion macros for the weighted outer product accumulator
// expects clk and arst_n in the scope of use
`ifndef WEIGHTED_OUTER_PRODUCT_ACCUMULATOR_DEFINES_SVH
`define WEIGHTED_OUTER_PRODUCT_ACCUMULATOR_DEFINES_SVH
`ifndef SYNTH
`define WOPA_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define WOPA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define WOPA_ASSERT_SAME(lbl, ante, cons)
`define WOPA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hdl/wopa_pkg.sv]
// shared types, constants and helpers of the weighted outer product accumulator
// no dependencies
package wopa_pkg;
	localparam int unsigned MAX_SIZE_DEF = 64;

	typedef enum logic [1:0] {
		REQ_PUSH  = 2'd0,
		REQ_RDMAT = 2'd1,
		REQ_RDVEC = 2'd2,
		REQ_CLEAR = 2'd3
	} req_t;

	function automatic logic [31:0] mag32(input logic [31:0] v);
		mag32 = v[31] ? (32'd0 - v) : v;
	endfunction
endpackage

[hdl/wopa_ram.sv]
// generic single write port ram with registered read
// no dependencies
module wopa_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[hdl/weighted_outer_product_accumulator.sv]
// top level of the weighted outer product accumulator
// depends on wopa_pkg, wopa_ram and the assertion macro header
//
// channel  signals                                              direction
// request  start req_type o_value weight energy
//          last_element row col                                 in
// result   busy done read_data error saturated                  out
// config   cfg_wr_en cfg_wr_data                                in
//
// push without last: result next cycle, next word may follow at once
// an update of n elements steps ST_WE, then per row ST_RI ST_LI, per column
// ST_RJ ST_LJ, each then ST_LO ST_HI ST_RND ST_ACC, one ram port per store
// clear and reset: sweep zeroing the matrix and vector rams, busy held
// results are strobed by done for one cycle; the receiver cannot stall
`include "weighted_outer_product_accumulator_defines.svh"
module weighted_outer_product_accumulator #(
	parameter int unsigned MAX_SIZE = wopa_pkg::MAX_SIZE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [6:0]         cfg_wr_data,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         req_type,
	input  logic signed [31:0] o_value,
	input  logic [31:0]        weight,
	input  logic signed [31:0] energy,
	input  logic               last_element,
	input  logic [5:0]         row,
	input  logic [5:0]         col,
	output logic               done,
	output logic signed [63:0] read_data,
	output logic               error,
	output logic               saturated
);
	import wopa_pkg::*;

	localparam int unsigned IW  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int unsigned CW  = $clog2(MAX_SIZE + 1);
	localparam int unsigned MD  = MAX_SIZE * MAX_SIZE;
	localparam int unsigned MAW = (MD > 1) ? $clog2(MD) : 1;

	typedef enum logic [11:0] {
		ST_IDLE = 12'b000000000001,
		ST_CLR  = 12'b000000000010,
		ST_RD   = 12'b000000000100,
		ST_WE   = 12'b000000001000,
		ST_RI   = 12'b000000010000,
		ST_LI   = 12'b000000100000,
		ST_RJ   = 12'b000001000000,
		ST_LJ   = 12'b000010000000,
		ST_LO   = 12'b000100000000,
		ST_HI   = 12'b001000000000,
		ST_RND  = 12'b010000000000,
		ST_ACC  = 12'b100000000000
	} state_t;

	state_t           state_q;
	logic [6:0]       size_q;
	logic [CW-1:0]    n_eff;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    cnt_next;
	logic             sat_q;
	logic [MAW-1:0]   clr_q;
	logic             clr_reply_q;
	logic             rd_vec_q;
	logic             rd_err_q;
	logic             push_err_q;
	logic [31:0]      w_q;
	logic [31:0]      me_q;
	logic             ne_q;
	logic [63:0]      we_q;
	logic [IW-1:0]    i_q;
	logic [IW-1:0]    j_q;
	logic [IW-1:0]    last_q;
	logic [MAW-1:0]   rbase_q;
	logic [31:0]      mi_q;
	logic             ni_q;
	logic             vec_q;
	logic [63:0]      a_q;
	logic [31:0]      b_q;
	logic             neg_q;
	logic signed [63:0] old_q;
	logic [63:0]      lo_q;
	logic [63:0]      hi_q;
	logic signed [63:0] term_q;
	logic             tsat_q;
	logic             done_q;
	logic signed [63:0] data_q;
	logic             err_q;

	logic             accept;
	logic [8:0]       row9;
	logic [8:0]       col9;
	logic             row_ok;
	logic             col_ok;
	logic [95:0]      full;
	logic [63:0]      tmag;
	logic             tovf;
	logic signed [63:0] tval;
	logic             tsat;
	logic signed [63:0] sum;
	logic             ovf_add;
	logic signed [63:0] acc_val;
	logic [31:0]      sv_rd;
	logic [63:0]      vr_rd;
	logic [63:0]      mr_rd;
	logic             sv_we;
	logic [IW-1:0]    sv_ra;
	logic             vr_we;
	logic [IW-1:0]    vr_wa;
	logic [63:0]      vr_wd;
	logic [IW-1:0]    vr_ra;
	logic             mr_we;
	logic [MAW-1:0]   mr_wa;
	logic [63:0]      mr_wd;
	logic [MAW-1:0]   mr_ra;
	logic [MAW-1:0]   k_addr;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign row9    = {3'd0, row};
	assign col9    = {3'd0, col};

	always_comb begin
		if (size_q == 7'd0) begin
			n_eff = CW'(1);
		end else if ({2'd0, size_q} > 9'(MAX_SIZE)) begin
			n_eff = CW'(MAX_SIZE);
		end else begin
			n_eff = CW'(size_q);
		end
	end

	assign row_ok   = row9 < 9'(n_eff);
	assign col_ok   = col9 < 9'(n_eff);
	assign cnt_next = (cnt_q < n_eff) ? cnt_q + CW'(1) : cnt_q;
	assign k_addr   = rbase_q + MAW'(j_q);

	// rounded q32.32 term from the partial products
	always_comb begin
		full = {hi_q, 32'd0} + {32'd0, lo_q} + 96'h8000;
		tmag = full[79:16];
		tovf = |full[95:80];
		tsat = 1'b0;
		if (!neg_q) begin
			if (tovf || tmag[63]) begin
				tval = 64'sh7FFF_FFFF_FFFF_FFFF;
				tsat = 1'b1;
			end else begin
				tval = $signed(tmag);
			end
		end else begin
			if (tovf || (tmag[63] && (|tmag[62:0]))) begin
				tval = 64'sh8000_0000_0000_0000;
				tsat = 1'b1;
			end else begin
				tval = $signed(64'd0 - tmag);
			end
		end
	end

	always_comb begin
		sum     = old_q + term_q;
		ovf_add = (old_q[63] == term_q[63]) && (sum[63] != term_q[63]);
		if (ovf_add) begin
			acc_val = term_q[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
		end else begin
			acc_val = sum;
		end
	end

	// ram port control
	always_comb begin
		sv_we = accept && (req_type == REQ_PUSH) && (cnt_q < n_eff);
		sv_ra = (state_q == ST_RI) ? i_q : j_q;
		vr_we = 1'b0;
		vr_wa = i_q;
		vr_wd = acc_val;
		vr_ra = (state_q == ST_IDLE) ? row9[IW-1:0] : i_q;
		mr_we = 1'b0;
		mr_wa = k_addr;
		mr_wd = acc_val;
		mr_ra = (state_q == ST_IDLE) ?
			MAW'(row9[IW-1:0]) * MAW'(MAX_SIZE) + MAW'(col9[IW-1:0]) : k_addr;
		if (state_q == ST_CLR) begin
			mr_we = 1'b1;
			mr_wa = clr_q;
			mr_wd = 64'd0;
			vr_we = ({{(32-MAW){1'b0}}, clr_q} < 32'(MAX_SIZE));
			vr_wa = clr_q[IW-1:0];
			vr_wd = 64'd0;
		end else if (state_q == ST_ACC) begin
			vr_we = vec_q;
			mr_we = !vec_q;
		end
	end

	wopa_ram #(.WIDTH(32), .DEPTH(MAX_SIZE)) u_sample (
		.clk(clk), .we(sv_we), .waddr(cnt_q[IW-1:0]), .wdata(o_value),
		.raddr(sv_ra), .rdata(sv_rd)
	);

	wopa_ram #(.WIDTH(64), .DEPTH(MAX_SIZE)) u_vec (
		.clk(clk), .we(vr_we), .waddr(vr_wa), .wdata(vr_wd),
		.raddr(vr_ra), .rdata(vr_rd)
	);

	wopa_ram #(.WIDTH(64), .DEPTH(MD)) u_mat (
		.clk(clk), .we(mr_we), .waddr(mr_wa), .wdata(mr_wd),
		.raddr(mr_ra), .rdata(mr_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			size_q      <= 7'(MAX_SIZE);
			cnt_q       <= '0;
			sat_q       <= 1'b0;
			clr_q       <= '0;
			clr_reply_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_wr_en) begin
				size_q <= cfg_wr_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (req_t'(req_type))
							REQ_PUSH: begin
								push_err_q <= !(cnt_q < n_eff);
								if (last_element) begin
									cnt_q   <= '0;
									last_q  <= IW'((cnt_next > n_eff ? n_eff : cnt_next)
										- CW'(1));
									w_q     <= weight;
									me_q    <= mag32(energy);
									ne_q    <= energy[31];
									i_q     <= '0;
									rbase_q <= '0;
									state_q <= ST_WE;
								end else begin
									cnt_q  <= cnt_next;
									done_q <= 1'b1;
									data_q <= '0;
									err_q  <= !(cnt_q < n_eff);
								end
							end
							REQ_RDMAT: begin
								rd_vec_q <= 1'b0;
								rd_err_q <= !(row_ok && col_ok);
								state_q  <= ST_RD;
							end
							REQ_RDVEC: begin
								rd_vec_q <= 1'b1;
								rd_err_q <= !row_ok;
								state_q  <= ST_RD;
							end
							REQ_CLEAR: begin
								cnt_q       <= '0;
								sat_q       <= 1'b0;
								clr_q       <= '0;
								clr_reply_q <= 1'b1;
								state_q     <= ST_CLR;
							end
							default: ;
						endcase
					end
				end
				ST_CLR: begin
					if (clr_q == MAW'(MD - 1)) begin
						state_q <= ST_IDLE;
						if (clr_reply_q) begin
							done_q <= 1'b1;
							data_q <= '0;
							err_q  <= 1'b0;
						end
						clr_reply_q <= 1'b0;
					end else begin
						clr_q <= clr_q + MAW'(1);
					end
				end
				ST_RD: begin
					done_q  <= 1'b1;
					err_q   <= rd_err_q;
					data_q  <= rd_err_q ? 64'sd0 : $signed(rd_vec_q ? vr_rd : mr_rd);
					state_q <= ST_IDLE;
				end
				ST_WE: begin
					we_q    <= w_q * me_q;
					state_q <= ST_RI;
				end
				ST_RI: begin
					state_q <= ST_LI;
				end
				ST_LI: begin
					mi_q    <= mag32(sv_rd);
					ni_q    <= sv_rd[31];
					a_q     <= we_q;
					b_q     <= mag32(sv_rd);
					neg_q   <= ne_q ^ sv_rd[31];
					old_q   <= $signed(vr_rd);
					vec_q   <= 1'b1;
					state_q <= ST_LO;
				end
				ST_RJ: begin
					state_q <= ST_LJ;
				end
				ST_LJ: begin
					a_q     <= mi_q * mag32(sv_rd);
					b_q     <= w_q;
					neg_q   <= ni_q ^ sv_rd[31];
					old_q   <= $signed(mr_rd);
					vec_q   <= 1'b0;
					state_q <= ST_LO;
				end
				ST_LO: begin
					lo_q    <= a_q[31:0] * b_q;
					state_q <= ST_HI;
				end
				ST_HI: begin
					hi_q    <= a_q[63:32] * b_q;
					state_q <= ST_RND;
				end
				ST_RND: begin
					term_q  <= tval;
					tsat_q  <= tsat;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (tsat_q || ovf_add) begin
						sat_q <= 1'b1;
					end
					if (vec_q) begin
						j_q     <= '0;
						state_q <= ST_RJ;
					end else if (j_q != last_q) begin
						j_q     <= j_q + IW'(1);
						state_q <= ST_RJ;
					end else if (i_q != last_q) begin
						i_q     <= i_q + IW'(1);
						rbase_q <= rbase_q + MAW'(MAX_SIZE);
						state_q <= ST_RI;
					end else begin
						done_q  <= 1'b1;
						data_q  <= '0;
						err_q   <= push_err_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done      = done_q;
	assign read_data = data_q;
	assign error     = err_q;
	assign saturated = sat_q;

	`WOPA_ASSERT_SAME(a_done_after_work, done, $past(busy) || $past(start))
	`WOPA_ASSERT_SAME(a_err_zero_data, done && error, read_data == 64'sd0)
	`WOPA_ASSERT_SAME(a_count_bound, 1'b1, cnt_q <= CW'(MAX_SIZE))
	`WOPA_ASSERT_NEXT(a_clear_drops_flag, accept && (req_type == REQ_CLEAR), !saturated)
endmodule
